// File: rtl/hrdp_pkg.sv
// ----------------------------------------------------------------------------
// hrdp_pkg
// Shared types, codes and helpers for the HID report descriptor parser.
// ----------------------------------------------------------------------------
package hrdp_pkg;

    // default sizes of the parser stores
    localparam int STACK_DEPTH_DEF = 8;
    localparam int USAGE_DEPTH_DEF = 16;
    localparam int MAX_RECORDS_DEF = 64;
    localparam int REPORT_IDS_DEF  = 256;

    // item type field of a short item header
    localparam logic [1:0] TYPE_MAIN   = 2'd0;
    localparam logic [1:0] TYPE_GLOBAL = 2'd1;
    localparam logic [1:0] TYPE_LOCAL  = 2'd2;

    // size code meaning four data bytes
    localparam logic [1:0] SIZE_CODE_FOUR = 2'd3;

    // global tags
    localparam logic [3:0] TAG_USAGE_PAGE  = 4'd0;
    localparam logic [3:0] TAG_LOGICAL_MIN = 4'd1;
    localparam logic [3:0] TAG_LOGICAL_MAX = 4'd2;
    localparam logic [3:0] TAG_REPORT_SIZE = 4'd7;
    localparam logic [3:0] TAG_REPORT_ID   = 4'd8;
    localparam logic [3:0] TAG_REPORT_CNT  = 4'd9;
    localparam logic [3:0] TAG_PUSH        = 4'd10;
    localparam logic [3:0] TAG_POP         = 4'd11;

    // local tags
    localparam logic [3:0] TAG_USAGE     = 4'd0;
    localparam logic [3:0] TAG_USAGE_MIN = 4'd1;
    localparam logic [3:0] TAG_USAGE_MAX = 4'd2;

    // main tags
    localparam logic [3:0] TAG_INPUT   = 4'd8;
    localparam logic [3:0] TAG_OUTPUT  = 4'd9;
    localparam logic [3:0] TAG_FEATURE = 4'd11;

    // report kinds
    localparam logic [1:0] KIND_INPUT   = 2'd0;
    localparam logic [1:0] KIND_OUTPUT  = 2'd1;
    localparam logic [1:0] KIND_FEATURE = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EXEC,
        S_FILL,
        S_READ,
        S_MUL,
        S_SUM,
        S_EMIT,
        S_WRITE,
        S_CLEAR
    } state_t;

    // commands from controller to datapath
    typedef struct packed {
        logic       take_byte;
        logic       exec_item;
        logic       fill;
        logic [1:0] fill_kind;
        logic       set_used;
        logic       mem_read;
        logic       load_total;
        logic       sum_total;
        logic       emit;
        logic       write_back;
        logic       clear_all;
    } cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic completes;
        logic io_main;
        logic used;
        logic has_records;
        logic last_record;
        logic out_free;
    } sts_t;

    // saturate a 32-bit value to 16 bits
    function automatic logic [15:0] sat16(input logic [31:0] v);
        return (v[31:16] != 16'd0) ? 16'hFFFF : v[15:0];
    endfunction

    // sign extend by data length
    function automatic logic [31:0] sext(input logic [31:0] v, input logic [2:0] len);
        logic [31:0] r;
        r = v;
        if (len == 3'd1)
        begin
            r = {{24{v[7]}}, v[7:0]};
        end
        else if (len == 3'd2)
        begin
            r = {{16{v[15]}}, v[15:0]};
        end
        return r;
    endfunction

endpackage

// File: rtl/hid_report_descriptor_parser_unit.sv
// Parses a USB HID report descriptor taken one byte per transfer and issues one
// field record per transfer for each Input, Output or Feature item. Each
// completed item is executed after its last byte is taken. A completed Input,
// Output or Feature item reads its bit total from memory, loads it together with
// the field product, sums the two, emits its records and writes the total back;
// the first time its report id is seen, the fill states first set that id's row
// of the bit total memory (one write port, registered read). Records of one main
// item come out one per cycle while the record side keeps up, from a single
// shared usage walk. After a byte marked final the parser clears its state.
// ----------------------------------------------------------------------------
// hid_report_descriptor_parser_unit
// Top level of the HID report descriptor parser: sequencer and datapath.
// ----------------------------------------------------------------------------
module hid_report_descriptor_parser_unit import hrdp_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF,
    parameter int USAGE_DEPTH = USAGE_DEPTH_DEF,
    parameter int MAX_RECORDS = MAX_RECORDS_DEF,
    parameter int REPORT_IDS  = REPORT_IDS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        descriptor_valid,
    output logic        descriptor_stall,
    input  logic [7:0]  descriptor_byte,
    input  logic        final_byte,
    output logic        record_valid,
    input  logic        record_stall,
    output logic [7:0]  report_number,
    output logic [1:0]  report_kind,
    output logic [15:0] start_bit,
    output logic [15:0] bit_width,
    output logic [15:0] repeat_count,
    output logic signed [31:0] least_logical,
    output logic signed [31:0] greatest_logical,
    output logic [31:0] main_flags,
    output logic [31:0] first_usage,
    output logic [31:0] final_usage,
    output logic        end_of_run,
    output logic        overflow
);

    cmd_t cmd;
    sts_t sts;

    // sequencer
    hrdp_ctrl u_ctrl
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .descriptor_valid (descriptor_valid),
        .final_byte       (final_byte),
        .sts              (sts),
        .cmd              (cmd),
        .descriptor_stall (descriptor_stall)
    );

    // datapath
    hrdp_datapath #(
        .STACK_DEPTH (STACK_DEPTH),
        .USAGE_DEPTH (USAGE_DEPTH),
        .MAX_RECORDS (MAX_RECORDS),
        .REPORT_IDS  (REPORT_IDS)
    ) u_dp
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .sts              (sts),
        .descriptor_byte  (descriptor_byte),
        .record_stall     (record_stall),
        .record_valid     (record_valid),
        .report_number    (report_number),
        .report_kind      (report_kind),
        .start_bit        (start_bit),
        .bit_width        (bit_width),
        .repeat_count     (repeat_count),
        .least_logical    (least_logical),
        .greatest_logical (greatest_logical),
        .main_flags       (main_flags),
        .first_usage      (first_usage),
        .final_usage      (final_usage),
        .end_of_run       (end_of_run),
        .overflow         (overflow)
    );

    // a range record with a count other than one stands alone
    a_range_alone: assert property (@(posedge clk) disable iff (!rst_n)
        record_valid && repeat_count != 16'd1 |-> end_of_run)
        else $error("multi-count record is not the last of its run");

    // kind code is never the unused value
    a_kind_code: assert property (@(posedge clk) disable iff (!rst_n)
        record_valid |-> report_kind != 2'd3)
        else $error("record carries an unused kind code");

    // records appear only while the parser is busy with a main item
    a_emit_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(record_valid) |-> $past(descriptor_stall))
        else $error("record issued while parser was idle");

endmodule

// File: rtl/hrdp_ctrl.sv
// ----------------------------------------------------------------------------
// hrdp_ctrl
// Sequencer of the parser: byte intake, item execution, layout memory
// access and record emission.
// ----------------------------------------------------------------------------
module hrdp_ctrl import hrdp_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic descriptor_valid,
    input  logic final_byte,
    input  sts_t sts,
    output cmd_t cmd,
    output logic descriptor_stall
);

    state_t     state_reg, state_next;
    logic       final_reg, final_next;
    logic [1:0] fill_reg, fill_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            final_reg <= 1'b0;
            fill_reg  <= KIND_INPUT;
        end
        else
        begin
            state_reg <= state_next;
            final_reg <= final_next;
            fill_reg  <= fill_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next    = state_reg;
        final_next    = final_reg;
        fill_next     = fill_reg;
        cmd           = '0;
        cmd.fill_kind = fill_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (descriptor_valid)
                begin
                    cmd.take_byte = 1'b1;
                    final_next    = final_byte;
                    if (sts.completes)
                    begin
                        state_next = S_EXEC;
                    end
                    else if (final_byte)
                    begin
                        state_next = S_CLEAR;
                    end
                end
            end
            S_EXEC:
            begin
                if (sts.io_main)
                begin
                    fill_next  = KIND_INPUT;
                    state_next = sts.used ? S_READ : S_FILL;
                end
                else
                begin
                    cmd.exec_item = 1'b1;
                    state_next    = final_reg ? S_CLEAR : S_IDLE;
                end
            end
            S_FILL:
            begin
                cmd.fill  = 1'b1;
                fill_next = fill_reg + 2'd1;
                if (fill_reg == KIND_FEATURE)
                begin
                    cmd.set_used = 1'b1;
                    state_next   = S_READ;
                end
            end
            S_READ:
            begin
                cmd.mem_read = 1'b1;
                state_next   = S_MUL;
            end
            S_MUL:
            begin
                cmd.load_total = 1'b1;
                state_next     = S_SUM;
            end
            S_SUM:
            begin
                cmd.sum_total = 1'b1;
                state_next    = S_EMIT;
            end
            S_EMIT:
            begin
                if (!sts.has_records)
                begin
                    state_next = S_WRITE;
                end
                else if (sts.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (sts.last_record)
                    begin
                        state_next = S_WRITE;
                    end
                end
            end
            S_WRITE:
            begin
                cmd.write_back = 1'b1;
                state_next     = final_reg ? S_CLEAR : S_IDLE;
            end
            S_CLEAR:
            begin
                cmd.clear_all = 1'b1;
                final_next    = 1'b0;
                state_next    = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign descriptor_stall = (state_reg != S_IDLE);

endmodule

// File: rtl/hrdp_datapath.sv
// ----------------------------------------------------------------------------
// hrdp_datapath
// Item gathering, global and local state, push/pop stack, usage list,
// per-report bit totals and the record output register.
// ----------------------------------------------------------------------------
module hrdp_datapath import hrdp_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF,
    parameter int USAGE_DEPTH = USAGE_DEPTH_DEF,
    parameter int MAX_RECORDS = MAX_RECORDS_DEF,
    parameter int REPORT_IDS  = REPORT_IDS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  cmd_t        cmd,
    output sts_t        sts,
    input  logic [7:0]  descriptor_byte,
    input  logic        record_stall,
    output logic        record_valid,
    output logic [7:0]  report_number,
    output logic [1:0]  report_kind,
    output logic [15:0] start_bit,
    output logic [15:0] bit_width,
    output logic [15:0] repeat_count,
    output logic signed [31:0] least_logical,
    output logic signed [31:0] greatest_logical,
    output logic [31:0] main_flags,
    output logic [31:0] first_usage,
    output logic [31:0] final_usage,
    output logic        end_of_run,
    output logic        overflow
);

    localparam int SP_W   = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int SC_W   = $clog2(STACK_DEPTH + 1);
    localparam int UI_W   = (USAGE_DEPTH > 1) ? $clog2(USAGE_DEPTH) : 1;
    localparam int UC_W   = $clog2(USAGE_DEPTH + 1);
    localparam int RC_W   = $clog2(MAX_RECORDS + 1);
    localparam int ID_W   = (REPORT_IDS > 1) ? $clog2(REPORT_IDS) : 1;
    localparam int SLOTS  = REPORT_IDS * 3;
    localparam int SLOT_W = $clog2(SLOTS);

    // item gathering
    logic [7:0]  header_reg;
    logic [2:0]  pending_reg;
    logic [31:0] gather_reg;
    logic [1:0]  pos_reg;

    // global state
    logic [15:0] page_reg;
    logic [31:0] lo_reg, hi_reg;
    logic [15:0] bw_reg, rep_reg;
    logic [7:0]  rn_reg;

    // stack and usage list
    logic [63:0]     stk_lim  [STACK_DEPTH];
    logic [55:0]     stk_misc [STACK_DEPTH];
    logic [SC_W-1:0] sc_reg;
    logic [32:0]     ulow  [USAGE_DEPTH];
    logic [31:0]     uhigh [USAGE_DEPTH];
    logic [UC_W-1:0] ue_reg;

    // layout memory and valid bits
    logic [15:0]           layout_mem [SLOTS];
    logic [15:0]           rd_reg;
    logic [REPORT_IDS-1:0] used_reg;

    // record walk
    logic [15:0]     total_reg, fin_reg;
    logic [31:0]     prod_reg;
    logic            ovf_reg, single_reg;
    logic [RC_W-1:0] nrec_reg, rec_reg, off_reg;
    logic [UI_W-1:0] item_reg;
    logic            out_valid_reg;

    // report id to table row
    logic [ID_W-1:0] id_lut [256];
    for (genvar gi = 0; gi < 256; gi++)
    begin : g_lut
        assign id_lut[gi] = ID_W'(gi % REPORT_IDS);
    end

    // header decode
    logic [1:0]  code, itype;
    logic [3:0]  tag;
    logic [2:0]  len, len_in;
    logic [1:0]  kind;
    logic        io_main, is_glob, is_loc;
    logic [31:0] usage_word, gather_ins;
    logic [ID_W-1:0]   idx;
    logic [SLOT_W-1:0] slot_kind, slot_fill, slot_base;
    logic [SC_W-1:0]   sc_dec;
    logic [UC_W-1:0]   ue_dec;

    assign code    = header_reg[1:0];
    assign itype   = header_reg[3:2];
    assign tag     = header_reg[7:4];
    assign len     = (code == SIZE_CODE_FOUR) ? 3'd4 : {1'b0, code};
    assign len_in  = (descriptor_byte[1:0] == SIZE_CODE_FOUR) ? 3'd4
                                                              : {1'b0, descriptor_byte[1:0]};
    assign is_glob = (itype == TYPE_GLOBAL);
    assign is_loc  = (itype == TYPE_LOCAL);
    assign io_main = (itype == TYPE_MAIN) &&
                     (tag == TAG_INPUT || tag == TAG_OUTPUT || tag == TAG_FEATURE);
    assign kind    = (tag == TAG_INPUT) ? KIND_INPUT :
                     (tag == TAG_OUTPUT) ? KIND_OUTPUT : KIND_FEATURE;
    assign usage_word = (len == 3'd4) ? gather_reg : {page_reg, gather_reg[15:0]};
    assign gather_ins = gather_reg | ({24'd0, descriptor_byte} << {pos_reg, 3'b000});
    assign idx        = id_lut[rn_reg];
    assign slot_base  = SLOT_W'({idx, 1'b0}) + SLOT_W'(idx);
    assign slot_kind  = slot_base + SLOT_W'(kind);
    assign slot_fill  = slot_base + SLOT_W'(cmd.fill_kind);
    assign sc_dec     = sc_reg - SC_W'(1);
    assign ue_dec     = ue_reg - UC_W'(1);

    // usage walk step
    logic        in_list, cur_below, next_in_list;
    logic [31:0] cur;
    logic [16:0] run;
    logic [32:0] sum;
    logic        sum_over, single_now;

    assign in_list      = (UC_W'(item_reg) < ue_reg);
    assign cur          = in_list ? (ulow[item_reg][31:0] + 32'(off_reg)) : 32'd0;
    assign cur_below    = cur < uhigh[item_reg];
    assign next_in_list = (UC_W'(item_reg) + UC_W'(1)) < ue_reg;
    assign run          = {1'b0, total_reg} + {1'b0, bw_reg};
    assign sum          = {17'd0, total_reg} + {1'b0, prod_reg};
    assign sum_over     = sum > 33'h0FFFF;
    assign single_now   = !gather_reg[1] && (ue_reg == UC_W'(1)) && ulow[0][32];

    // status
    always_comb
    begin
        sts             = '0;
        sts.completes   = (pending_reg == 3'd0) ? (descriptor_byte[1:0] == 2'd0)
                                                : (pending_reg == 3'd1);
        sts.io_main     = io_main;
        sts.used        = used_reg[idx];
        sts.has_records = (nrec_reg != '0);
        sts.last_record = (rec_reg == nrec_reg - RC_W'(1));
        sts.out_free    = !out_valid_reg || !record_stall;
    end

    // control and global state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg   <= 3'd0;
            pos_reg       <= 2'd0;
            page_reg      <= 16'd0;
            lo_reg        <= 32'd0;
            hi_reg        <= 32'd0;
            bw_reg        <= 16'd0;
            rep_reg       <= 16'd0;
            rn_reg        <= 8'd0;
            sc_reg        <= '0;
            ue_reg        <= '0;
            used_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.take_byte)
            begin
                if (pending_reg == 3'd0)
                begin
                    pos_reg     <= 2'd0;
                    pending_reg <= len_in;
                end
                else
                begin
                    pos_reg     <= pos_reg + 2'd1;
                    pending_reg <= pending_reg - 3'd1;
                end
            end
            if (cmd.exec_item && is_glob)
            begin
                case (tag)
                    TAG_USAGE_PAGE:  page_reg <= gather_reg[15:0];
                    TAG_LOGICAL_MIN: lo_reg   <= sext(gather_reg, len);
                    TAG_LOGICAL_MAX: hi_reg   <= sext(gather_reg, len);
                    TAG_REPORT_SIZE: bw_reg   <= sat16(gather_reg);
                    TAG_REPORT_ID:   rn_reg   <= gather_reg[7:0];
                    TAG_REPORT_CNT:  rep_reg  <= sat16(gather_reg);
                    TAG_PUSH:
                    begin
                        if (sc_reg < SC_W'(STACK_DEPTH))
                        begin
                            sc_reg <= sc_reg + SC_W'(1);
                        end
                    end
                    TAG_POP:
                    begin
                        if (sc_reg != '0)
                        begin
                            sc_reg   <= sc_dec;
                            lo_reg   <= stk_lim[sc_dec[SP_W-1:0]][31:0];
                            hi_reg   <= stk_lim[sc_dec[SP_W-1:0]][63:32];
                            page_reg <= stk_misc[sc_dec[SP_W-1:0]][55:40];
                            bw_reg   <= stk_misc[sc_dec[SP_W-1:0]][39:24];
                            rep_reg  <= stk_misc[sc_dec[SP_W-1:0]][23:8];
                            rn_reg   <= stk_misc[sc_dec[SP_W-1:0]][7:0];
                        end
                    end
                    default: ;
                endcase
            end
            if (cmd.exec_item && is_loc && (tag == TAG_USAGE || tag == TAG_USAGE_MIN))
            begin
                if (ue_reg < UC_W'(USAGE_DEPTH))
                begin
                    ue_reg <= ue_reg + UC_W'(1);
                end
            end
            // any main item ends the usage list
            if ((cmd.exec_item && itype == TYPE_MAIN) || cmd.write_back)
            begin
                ue_reg <= '0;
            end
            if (cmd.set_used)
            begin
                used_reg[idx] <= 1'b1;
            end
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!record_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cmd.clear_all)
            begin
                pending_reg <= 3'd0;
                pos_reg     <= 2'd0;
                page_reg    <= 16'd0;
                lo_reg      <= 32'd0;
                hi_reg      <= 32'd0;
                bw_reg      <= 16'd0;
                rep_reg     <= 16'd0;
                rn_reg      <= 8'd0;
                sc_reg      <= '0;
                ue_reg      <= '0;
                used_reg    <= '0;
            end
        end
    end

    // header and data bytes
    always_ff @(posedge clk)
    begin
        if (cmd.take_byte)
        begin
            if (pending_reg == 3'd0)
            begin
                header_reg <= descriptor_byte;
                gather_reg <= 32'd0;
            end
            else
            begin
                gather_reg <= gather_ins;
            end
        end
    end

    // push/pop stack store
    always_ff @(posedge clk)
    begin
        if (cmd.exec_item && is_glob && tag == TAG_PUSH && sc_reg < SC_W'(STACK_DEPTH))
        begin
            stk_lim[sc_reg[SP_W-1:0]]  <= {hi_reg, lo_reg};
            stk_misc[sc_reg[SP_W-1:0]] <= {page_reg, bw_reg, rep_reg, rn_reg};
        end
    end

    // usage list store
    always_ff @(posedge clk)
    begin
        if (cmd.exec_item && is_loc)
        begin
            if ((tag == TAG_USAGE || tag == TAG_USAGE_MIN) && ue_reg < UC_W'(USAGE_DEPTH))
            begin
                ulow[ue_reg[UI_W-1:0]]  <= {(tag == TAG_USAGE_MIN), usage_word};
                uhigh[ue_reg[UI_W-1:0]] <= (tag == TAG_USAGE_MIN) ? 32'd0 : usage_word;
            end
            else if (tag == TAG_USAGE_MAX && ue_reg != '0)
            begin
                uhigh[ue_dec[UI_W-1:0]] <= usage_word;
            end
        end
    end

    // bit total memory
    always_ff @(posedge clk)
    begin
        if (cmd.fill)
        begin
            layout_mem[slot_fill] <= (rn_reg != 8'd0) ? 16'd8 : 16'd0;
        end
        else if (cmd.write_back)
        begin
            layout_mem[slot_kind] <= fin_reg;
        end
        if (cmd.mem_read)
        begin
            rd_reg <= layout_mem[slot_kind];
        end
    end

    // record walk and output register
    always_ff @(posedge clk)
    begin
        if (cmd.load_total)
        begin
            total_reg <= rd_reg;
            prod_reg  <= bw_reg * rep_reg;
            rec_reg   <= '0;
            off_reg   <= '0;
            item_reg  <= '0;
        end
        if (cmd.sum_total)
        begin
            fin_reg    <= sum_over ? 16'hFFFF : sum[15:0];
            single_reg <= single_now;
            if (single_now)
            begin
                nrec_reg <= RC_W'(1);
                ovf_reg  <= sum_over;
            end
            else if (rep_reg > 16'(MAX_RECORDS))
            begin
                nrec_reg <= RC_W'(MAX_RECORDS);
                ovf_reg  <= 1'b1;
            end
            else
            begin
                nrec_reg <= rep_reg[RC_W-1:0];
                ovf_reg  <= sum_over;
            end
        end
        if (cmd.emit)
        begin
            report_number    <= rn_reg;
            report_kind      <= kind;
            start_bit        <= total_reg;
            bit_width        <= bw_reg;
            least_logical    <= lo_reg;
            greatest_logical <= hi_reg;
            main_flags       <= gather_reg;
            end_of_run       <= sts.last_record;
            overflow         <= ovf_reg;
            rec_reg          <= rec_reg + RC_W'(1);
            if (single_reg)
            begin
                repeat_count <= rep_reg;
                first_usage  <= ulow[0][31:0];
                final_usage  <= uhigh[0];
            end
            else
            begin
                repeat_count <= 16'd1;
                first_usage  <= cur;
                final_usage  <= cur;
                total_reg    <= run[16] ? 16'hFFFF : run[15:0];
                if (in_list)
                begin
                    if (cur_below)
                    begin
                        off_reg <= off_reg + RC_W'(1);
                    end
                    else if (next_in_list)
                    begin
                        item_reg <= item_reg + UI_W'(1);
                        off_reg  <= '0;
                    end
                end
            end
        end
    end

    assign record_valid = out_valid_reg;

endmodule

// File: tb/sv/hid_report_descriptor_parser_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hid_report_descriptor_parser_unit_test
// Feeds HID report descriptors byte by byte through the parser and checks
// every field record against a predictor of the parser kept in the bench.
// ----------------------------------------------------------------------------
module hid_report_descriptor_parser_unit_test;
    import hrdp_pkg::*;

    // codes not in the package
    localparam logic [1:0] TYPE_RESERVED      = 2'd3;
    localparam logic [3:0] TAG_PHYS_MIN       = 4'd3;
    localparam logic [3:0] TAG_COLLECTION     = 4'd10;
    localparam logic [3:0] TAG_END_COLLECTION = 4'd12;
    localparam int IDLE_LIMIT = 5000;
    localparam int LONG_HOLD  = 400;

    typedef struct {
        logic [7:0]  rnum;
        logic [1:0]  kind;
        logic [15:0] start;
        logic [15:0] width;
        logic [15:0] cnt;
        logic [31:0] lmin;
        logic [31:0] lmax;
        logic [31:0] flags;
        logic [31:0] u_first;
        logic [31:0] u_last;
        logic        eor;
        logic        ovf;
    } field_rec_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic descriptor_valid = 1'b0;
    logic descriptor_stall;
    logic [7:0] descriptor_byte = 8'd0;
    logic final_byte = 1'b0;
    logic record_valid;
    logic record_stall = 1'b0;
    logic [7:0] report_number;
    logic [1:0] report_kind;
    logic [15:0] start_bit, bit_width, repeat_count;
    logic signed [31:0] least_logical, greatest_logical;
    logic [31:0] main_flags, first_usage, final_usage;
    logic end_of_run, overflow;

    hid_report_descriptor_parser_unit dut (.*);

    // bytes waiting to be driven: {final, byte}
    logic [8:0] descriptor_feed[$];
    field_rec_t pending_records[$];
    int bytes_queued = 0, bytes_taken = 0, records_seen = 0, mains_seen = 0;
    int errors = 0, idle_cycles = 0;

    // parser state mirrored in the bench
    logic [7:0]  hdr;
    logic [2:0]  to_gather;
    logic [31:0] gathered;
    logic [1:0]  gpos;
    logic [15:0] upage, bwidth, rcount;
    logic [31:0] lmin, lmax;
    logic [7:0]  rid;
    logic [63:0] stk_limits[STACK_DEPTH_DEF];
    logic [55:0] stk_misc[STACK_DEPTH_DEF];
    int          stk_n;
    logic [32:0] use_lo[USAGE_DEPTH_DEF];
    logic [31:0] use_hi[USAGE_DEPTH_DEF];
    int          use_n;
    logic [15:0] bit_totals[REPORT_IDS_DEF * 3];
    logic        id_seen[REPORT_IDS_DEF];

    function automatic logic [15:0] clip16(logic [31:0] v);
        return (v > 32'hFFFF) ? 16'hFFFF : v[15:0];
    endfunction

    function automatic logic [31:0] widen(logic [31:0] v, int len);
        if (len == 1) return {{24{v[7]}}, v[7:0]};
        if (len == 2) return {{16{v[15]}}, v[15:0]};
        return v;
    endfunction

    task automatic clear_parser();
        hdr = 0; to_gather = 0; gathered = 0; gpos = 0;
        upage = 0; lmin = 0; lmax = 0; bwidth = 0; rcount = 0; rid = 0;
        stk_n = 0; use_n = 0;
        foreach (id_seen[i]) id_seen[i] = 1'b0;
    endtask

    // field records of an input, output or feature item
    task automatic emit_fields(logic [1:0] kind, logic [31:0] flags);
        field_rec_t r, recs[$];
        int slot, item, off;
        logic [63:0] total;
        logic [31:0] cur;
        bit ovf;
        ovf = 0;
        if (!id_seen[rid])
        begin
            id_seen[rid] = 1'b1;
            for (int k = 0; k < 3; k++) bit_totals[rid * 3 + k] = (rid != 0) ? 16'd8 : 16'd0;
        end
        slot = rid * 3 + kind;
        total = bit_totals[slot];
        r.rnum = rid; r.kind = kind; r.width = bwidth; r.lmin = lmin; r.lmax = lmax;
        r.flags = flags; r.eor = 0; r.ovf = 0;
        if (!flags[1] && use_n == 1 && use_lo[0][32])
        begin
            r.start = total[15:0]; r.cnt = rcount;
            r.u_first = use_lo[0][31:0]; r.u_last = use_hi[0];
            recs.push_back(r);
            total += bwidth * rcount;
            if (total > 64'hFFFF) begin total = 64'hFFFF; ovf = 1; end
        end
        else
        begin
            item = 0; off = 0;
            for (int i = 0; i < rcount; i++)
            begin
                if (i >= MAX_RECORDS_DEF)
                begin
                    ovf = 1;
                    total += bwidth * (rcount - i);
                    break;
                end
                cur = 0;
                if (item < use_n)
                begin
                    cur = use_lo[item][31:0] + off;
                    if (cur < use_hi[item]) off++;
                    else if (item + 1 < use_n) begin item++; off = 0; end
                end
                r.start = total[15:0]; r.cnt = 1; r.u_first = cur; r.u_last = cur;
                recs.push_back(r);
                total += bwidth;
                if (total > 64'hFFFF) begin total = 64'hFFFF; ovf = 1; end
            end
            if (total > 64'hFFFF) begin total = 64'hFFFF; ovf = 1; end
        end
        bit_totals[slot] = total[15:0];
        if (recs.size() > 0) recs[recs.size() - 1].eor = 1;
        foreach (recs[k])
        begin
            recs[k].ovf = ovf;
            pending_records.push_back(recs[k]);
        end
    endtask

    // execute a completed item
    task automatic run_item();
        logic [1:0] ty;
        logic [3:0] tag;
        logic [31:0] full;
        int len;
        ty = hdr[3:2]; tag = hdr[7:4];
        len = (hdr[1:0] == SIZE_CODE_FOUR) ? 4 : hdr[1:0];
        if (ty == TYPE_MAIN)
        begin
            if (tag == TAG_INPUT) emit_fields(KIND_INPUT, gathered);
            else if (tag == TAG_OUTPUT) emit_fields(KIND_OUTPUT, gathered);
            else if (tag == TAG_FEATURE) emit_fields(KIND_FEATURE, gathered);
            use_n = 0;
        end
        else if (ty == TYPE_GLOBAL)
        begin
            case (tag)
                TAG_USAGE_PAGE:  upage = gathered[15:0];
                TAG_LOGICAL_MIN: lmin = widen(gathered, len);
                TAG_LOGICAL_MAX: lmax = widen(gathered, len);
                TAG_REPORT_SIZE: bwidth = clip16(gathered);
                TAG_REPORT_ID:   rid = gathered[7:0];
                TAG_REPORT_CNT:  rcount = clip16(gathered);
                TAG_PUSH:
                    if (stk_n < STACK_DEPTH_DEF)
                    begin
                        stk_limits[stk_n] = {lmax, lmin};
                        stk_misc[stk_n] = {upage, bwidth, rcount, rid};
                        stk_n++;
                    end
                TAG_POP:
                    if (stk_n > 0)
                    begin
                        stk_n--;
                        {lmax, lmin} = stk_limits[stk_n];
                        {upage, bwidth, rcount, rid} = stk_misc[stk_n];
                    end
                default: ;
            endcase
        end
        else if (ty == TYPE_LOCAL)
        begin
            full = (len == 4) ? gathered : {upage, gathered[15:0]};
            if (tag == TAG_USAGE || tag == TAG_USAGE_MIN)
            begin
                if (use_n < USAGE_DEPTH_DEF)
                begin
                    use_lo[use_n] = {tag == TAG_USAGE_MIN, full};
                    use_hi[use_n] = (tag == TAG_USAGE_MIN) ? 32'd0 : full;
                    use_n++;
                end
            end
            else if (tag == TAG_USAGE_MAX && use_n > 0)
                use_hi[use_n - 1] = full;
        end
    endtask

    task automatic parse_byte(logic [7:0] b, logic last);
        if (to_gather == 0)
        begin
            hdr = b; gathered = 0; gpos = 0;
            to_gather = (b[1:0] == SIZE_CODE_FOUR) ? 3'd4 : {1'b0, b[1:0]};
            if (to_gather == 0) run_item();
        end
        else
        begin
            gathered |= {24'd0, b} << (8 * gpos);
            gpos++;
            to_gather--;
            if (to_gather == 0) run_item();
        end
        if (last) clear_parser();
    endtask

    // queue one short item; last marks its final byte
    task automatic add_item(logic [1:0] ty, logic [3:0] tag, logic [1:0] code,
                            logic [31:0] data, bit last = 0);
        int n;
        n = (code == SIZE_CODE_FOUR) ? 4 : code;
        descriptor_feed.push_back({last && n == 0, tag, ty, code});
        for (int i = 0; i < n; i++)
            descriptor_feed.push_back({last && i == n - 1, data[8 * i +: 8]});
        bytes_queued += n + 1;
    endtask

    function automatic logic [1:0] any_code();
        return 2'($urandom_range(0, 3));
    endfunction

    // one random descriptor fragment, mostly well formed
    task automatic random_section();
        logic [1:0] code;
        int nu;
        if ($urandom_range(0, 5) == 0) add_item(TYPE_GLOBAL, TAG_PUSH, 0, 0);
        if ($urandom_range(0, 5) == 0) add_item(TYPE_GLOBAL, TAG_POP, 0, 0);
        if ($urandom_range(0, 2) == 0) add_item(TYPE_GLOBAL, TAG_USAGE_PAGE, any_code(), $urandom);
        if ($urandom_range(0, 2) == 0) add_item(TYPE_GLOBAL, TAG_LOGICAL_MIN, any_code(), $urandom);
        if ($urandom_range(0, 2) == 0) add_item(TYPE_GLOBAL, TAG_LOGICAL_MAX, any_code(), $urandom);
        if ($urandom_range(0, 3) == 0) add_item(TYPE_GLOBAL, TAG_REPORT_ID, 1, $urandom);
        if ($urandom_range(0, 15) == 0) add_item(TYPE_GLOBAL, TAG_REPORT_SIZE, 3, $urandom);
        else add_item(TYPE_GLOBAL, TAG_REPORT_SIZE, 1, $urandom_range(1, 16));
        if ($urandom_range(0, 20) == 0) add_item(TYPE_GLOBAL, TAG_REPORT_CNT, 1, 70);
        else add_item(TYPE_GLOBAL, TAG_REPORT_CNT, 1, $urandom_range(0, 6));
        if ($urandom_range(0, 1))
        begin
            add_item(TYPE_LOCAL, TAG_USAGE_MIN, any_code(), $urandom_range(0, 40));
            add_item(TYPE_LOCAL, TAG_USAGE_MAX, any_code(), $urandom_range(0, 48));
        end
        else
        begin
            nu = $urandom_range(0, 3);
            repeat (nu) add_item(TYPE_LOCAL, TAG_USAGE, any_code(), $urandom);
        end
        if ($urandom_range(0, 9) == 0)
        begin
            descriptor_feed.push_back({1'b0, 8'($urandom)});
            bytes_queued++;
        end
        case ($urandom_range(0, 7))
            0: add_item(TYPE_MAIN, TAG_COLLECTION, 1, $urandom);
            1, 2: add_item(TYPE_MAIN, TAG_OUTPUT, any_code(), $urandom);
            3: add_item(TYPE_MAIN, TAG_FEATURE, any_code(), $urandom);
            default: add_item(TYPE_MAIN, TAG_INPUT, any_code(), $urandom);
        endcase
    endtask

    // clock and reset
    initial
    begin
        forever #1 clk = ~clk;
    end

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
    end

    // byte driver and prediction on each accepted transfer
    int burst_left = 4, gap_left = 0;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            descriptor_valid <= 1'b0;
        end
        else
        begin
            if (descriptor_valid && !descriptor_stall)
            begin
                parse_byte(descriptor_byte, final_byte);
                bytes_taken++;
            end
            if (descriptor_valid && descriptor_stall)
                ;
            else if (gap_left > 0)
            begin
                gap_left--;
                descriptor_valid <= 1'b0;
            end
            else if (descriptor_feed.size() > 0)
            begin
                {final_byte, descriptor_byte} <= descriptor_feed.pop_front();
                descriptor_valid <= 1'b1;
                burst_left--;
                if (burst_left <= 0)
                begin
                    burst_left = $urandom_range(1, 24);
                    gap_left = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8);
                end
            end
            else
                descriptor_valid <= 1'b0;
        end
    end

    // record stall pattern, with one long hold-off
    int stall_phase = 0, hold_left = 0;
    bit hold_done = 0;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            record_stall <= 1'b0;
        end
        else
        begin
            stall_phase++;
            if (hold_left > 0)
            begin
                hold_left--;
                record_stall <= 1'b1;
            end
            else if (!hold_done && records_seen >= 40)
            begin
                hold_done = 1;
                hold_left = LONG_HOLD;
                record_stall <= 1'b1;
            end
            else
            begin
                case ((stall_phase / 64) % 3)
                    0: record_stall <= 1'b0;
                    1: record_stall <= ($urandom_range(0, 1) == 0);
                    default: record_stall <= ($urandom_range(0, 4) != 0);
                endcase
            end
        end
    end

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected %h, got %h", name, want, got);
            errors++;
        end
    endfunction

    // record monitor
    always @(posedge clk)
    begin
        field_rec_t e;
        if (rst_n && record_valid && !record_stall)
        begin
            records_seen++;
            if (pending_records.size() == 0)
            begin
                $error("record with none expected");
                errors++;
            end
            else
            begin
                e = pending_records.pop_front();
                if (e.eor) mains_seen++;
                check_field("report_number", e.rnum, report_number);
                check_field("report_kind", e.kind, report_kind);
                check_field("start_bit", e.start, start_bit);
                check_field("bit_width", e.width, bit_width);
                check_field("repeat_count", e.cnt, repeat_count);
                check_field("least_logical", e.lmin, least_logical);
                check_field("greatest_logical", e.lmax, greatest_logical);
                check_field("main_flags", e.flags, main_flags);
                check_field("first_usage", e.u_first, first_usage);
                check_field("final_usage", e.u_last, final_usage);
                check_field("end_of_run", e.eor, end_of_run);
                check_field("overflow", e.ovf, overflow);
            end
        end
    end

    // watchdog on cycles with no transfer
    always @(posedge clk)
    begin
        if ((descriptor_valid && !descriptor_stall) || (record_valid && !record_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // stimulus
    initial
    begin
        clear_parser();
        // pop on empty stack, usage max with no usage
        add_item(TYPE_GLOBAL, TAG_POP, 0, 0);
        add_item(TYPE_LOCAL, TAG_USAGE_MAX, 1, 8'h05);
        add_item(TYPE_GLOBAL, TAG_REPORT_SIZE, 1, 8);
        add_item(TYPE_GLOBAL, TAG_REPORT_CNT, 1, 3);
        add_item(TYPE_GLOBAL, TAG_LOGICAL_MIN, 1, 8'h80);
        add_item(TYPE_GLOBAL, TAG_LOGICAL_MAX, 2, 16'h7FFF);
        add_item(TYPE_GLOBAL, TAG_USAGE_PAGE, 1, 8'h07);
        // variable item walking a usage range
        add_item(TYPE_LOCAL, TAG_USAGE_MIN, 1, 8'hE0);
        add_item(TYPE_LOCAL, TAG_USAGE_MAX, 1, 8'hE7);
        add_item(TYPE_MAIN, TAG_INPUT, 1, 8'h02);
        // array over a single range gives one record
        add_item(TYPE_LOCAL, TAG_USAGE_MIN, 1, 8'h00);
        add_item(TYPE_LOCAL, TAG_USAGE_MAX, 1, 8'hFF);
        add_item(TYPE_MAIN, TAG_INPUT, 1, 8'h00);
        // report id at the top, four byte usage, output and feature
        add_item(TYPE_GLOBAL, TAG_REPORT_ID, 1, 8'hFF);
        add_item(TYPE_LOCAL, TAG_USAGE, 3, 32'h000C_00E9);
        add_item(TYPE_MAIN, TAG_OUTPUT, 0, 0);
        add_item(TYPE_MAIN, TAG_FEATURE, 3, 32'hFFFF_FFFF);
        // stack fills up, then restores
        repeat (STACK_DEPTH_DEF + 1) add_item(TYPE_GLOBAL, TAG_PUSH, 0, 0);
        add_item(TYPE_GLOBAL, TAG_REPORT_SIZE, 3, 32'h0001_2345);
        add_item(TYPE_GLOBAL, TAG_REPORT_CNT, 1, 2);
        add_item(TYPE_MAIN, TAG_INPUT, 1, 8'h02);
        add_item(TYPE_GLOBAL, TAG_POP, 0, 0);
        // usage list overflow and more than the record bound
        repeat (USAGE_DEPTH_DEF + 1) add_item(TYPE_LOCAL, TAG_USAGE, 1, $urandom);
        add_item(TYPE_GLOBAL, TAG_REPORT_SIZE, 1, 1);
        add_item(TYPE_GLOBAL, TAG_REPORT_CNT, 1, 70);
        add_item(TYPE_MAIN, TAG_FEATURE, 1, 8'h02);
        // reserved type, skipped global, other main item
        add_item(TYPE_RESERVED, 4'hF, 2, 16'hFFFF);
        add_item(TYPE_GLOBAL, TAG_PHYS_MIN, 1, 8'h11);
        add_item(TYPE_MAIN, TAG_END_COLLECTION, 0, 0, 1);
        // unfinished item cut by the final byte
        descriptor_feed.push_back({1'b0, TAG_USAGE_PAGE, TYPE_GLOBAL, 2'd2});
        descriptor_feed.push_back({1'b1, 8'h55});
        bytes_queued += 2;
        // sender waits until every record has come
        wait (bytes_taken == bytes_queued && pending_records.size() == 0);
        repeat (12) @(posedge clk);
        while (bytes_queued < 365)
        begin
            random_section();
            if ($urandom_range(0, 9) == 0)
            begin
                if ($urandom_range(0, 3) == 0)
                begin
                    descriptor_feed.push_back({1'b0, TAG_LOGICAL_MIN, TYPE_GLOBAL, 2'd3});
                    descriptor_feed.push_back({1'b1, 8'($urandom)});
                    bytes_queued += 2;
                end
                else
                    add_item(TYPE_MAIN, TAG_END_COLLECTION, 0, 0, 1);
            end
        end
        wait (bytes_taken == bytes_queued && pending_records.size() == 0);
        repeat (40) @(posedge clk);
        $display("run covered %0d descriptor bytes and %0d field records", bytes_taken,
                 records_seen);
        $display("in %0d main items, with stack, usage list and record overflow cases",
                 mains_seen);
        if (errors == 0 && pending_records.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// File: files.f
rtl/hrdp_pkg.sv
rtl/hrdp_ctrl.sv
rtl/hrdp_datapath.sv
rtl/hid_report_descriptor_parser_unit.sv
tb/sv/hid_report_descriptor_parser_unit_test.sv
